/* src/imu_rvc_pkg.sv */
// ----------------------------------------------------------------------------
// imu_rvc_pkg
// Shared types and constants of the serial IMU frame parser
// ----------------------------------------------------------------------------
package imu_rvc_pkg;

    localparam int WIN_LEN   = 19;
    localparam int FILL_W    = 5;
    localparam int CHK_POS   = 18;
    localparam int SUM_FIRST = 2;
    localparam int YAW_POS   = 3;
    localparam int PITCH_POS = 5;
    localparam int ROLL_POS  = 7;

    localparam logic [7:0] HDR_BYTE = 8'hAA;

    localparam logic [1:0] STATUS_NONE = 2'd0;
    localparam logic [1:0] STATUS_GOOD = 2'd1;
    localparam logic [1:0] STATUS_BAD  = 2'd2;

    typedef struct packed {
        logic [7:0] rx_byte;
    } rx_item_t;

    typedef struct packed {
        logic [1:0]         frame_status;
        logic signed [15:0] yaw_centideg;
        logic signed [15:0] pitch_centideg;
        logic signed [15:0] roll_centideg;
        logic [31:0]        good_frames;
        logic [31:0]        bad_frames;
    } frame_item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [15:0] yaw;
        logic signed [15:0] pitch;
        logic signed [15:0] roll;
    } entry_t;

    typedef struct packed {
        logic   push;
        entry_t entry;
    } push_t;

endpackage

/* src/imu_rvc_stream_if.sv */
// ----------------------------------------------------------------------------
// imu_rvc_stream_if
// Valid/ready channel carrying one payload item per transfer
// ----------------------------------------------------------------------------
interface imu_rvc_stream_if #(
    parameter type payload_t = logic [7:0]
) ();

    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
    modport monitor (input valid, input data, input ready);

endinterface

/* src/imu_rvc_front.sv */
// ----------------------------------------------------------------------------
// imu_rvc_front
// Byte window, header match and checksum; classifies each byte into an entry
// ----------------------------------------------------------------------------
module imu_rvc_front
    import imu_rvc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    imu_rvc_stream_if.sink      rx,
    input  logic                q_ready,
    output push_t               q_push
);

    logic [7:0]        win_reg [WIN_LEN];
    logic [7:0]        win_next [WIN_LEN];
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic [FILL_W-1:0] fill_inc;
    logic              was_full;
    logic              now_full;
    logic              header;
    logic              good;
    logic              check;
    logic              accept;
    logic [7:0]        lvl1 [8];
    logic [7:0]        lvl2 [4];
    logic [7:0]        lvl3 [2];
    logic [7:0]        sum;

    assign rx.ready = q_ready;
    assign accept   = rx.valid && q_ready;
    assign was_full = (fill_reg == FILL_W'(WIN_LEN));
    assign fill_inc = was_full ? fill_reg : fill_reg + FILL_W'(1);
    assign now_full = (fill_inc == FILL_W'(WIN_LEN));

    always_comb
    begin
        for (int i = 0; i < WIN_LEN; i++)
        begin
            if (was_full)
            begin
                win_next[i] = (i == WIN_LEN - 1) ? rx.data.rx_byte : win_reg[(i + 1) % WIN_LEN];
            end
            else
            begin
                win_next[i] = (fill_reg == FILL_W'(i)) ? rx.data.rx_byte : win_reg[i];
            end
        end
    end

    // checksum over bytes two to seventeen as a balanced tree
    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            lvl1[i] = win_next[SUM_FIRST + 2 * i] + win_next[SUM_FIRST + 2 * i + 1];
        end
        for (int i = 0; i < 4; i++)
        begin
            lvl2[i] = lvl1[2 * i] + lvl1[2 * i + 1];
        end
        for (int i = 0; i < 2; i++)
        begin
            lvl3[i] = lvl2[2 * i] + lvl2[2 * i + 1];
        end
        sum = lvl3[0] + lvl3[1];
    end

    assign header = (win_next[0] == HDR_BYTE) && (win_next[1] == HDR_BYTE);
    assign check  = now_full && header;
    assign good   = check && (sum == win_next[CHK_POS]);

    assign fill_next = good ? '0 : fill_inc;

    always_comb
    begin
        q_push.push        = accept;
        q_push.entry.status = good ? STATUS_GOOD : (check ? STATUS_BAD : STATUS_NONE);
        q_push.entry.yaw   = {win_next[YAW_POS + 1], win_next[YAW_POS]};
        q_push.entry.pitch = {win_next[PITCH_POS + 1], win_next[PITCH_POS]};
        q_push.entry.roll  = {win_next[ROLL_POS + 1], win_next[ROLL_POS]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else if (accept)
        begin
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < WIN_LEN; i++)
            begin
                win_reg[i] <= win_next[i];
            end
        end
    end

endmodule

/* src/imu_rvc_queue.sv */
// ----------------------------------------------------------------------------
// imu_rvc_queue
// Small first-in first-out queue of classified entries
// ----------------------------------------------------------------------------
module imu_rvc_queue
    import imu_rvc_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  push_t  q_push,
    output logic   q_ready,
    input  logic   q_pop,
    output logic   q_valid,
    output entry_t q_entry
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t           mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign q_ready = (count_reg != CNT_W'(DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_entry = mem_reg[rd_ptr_reg];
    assign do_push = q_push.push && q_ready;
    assign do_pop  = q_pop && q_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= q_push.entry;
        end
    end

endmodule

/* src/imu_rvc_back.sv */
// ----------------------------------------------------------------------------
// imu_rvc_back
// Angle holds, frame counters and the registered result stage
// ----------------------------------------------------------------------------
module imu_rvc_back
    import imu_rvc_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    input  entry_t          q_entry,
    output logic            q_pop,
    imu_rvc_stream_if.source frame
);

    logic signed [15:0] yaw_reg;
    logic signed [15:0] pitch_reg;
    logic signed [15:0] roll_reg;
    logic [31:0]        good_reg;
    logic [31:0]        bad_reg;
    logic signed [15:0] yaw_next;
    logic signed [15:0] pitch_next;
    logic signed [15:0] roll_next;
    logic [31:0]        good_next;
    logic [31:0]        bad_next;
    logic               out_valid_reg;
    frame_item_t        out_reg;
    logic               is_good;
    logic               is_bad;

    assign q_pop   = q_valid && (!out_valid_reg || frame.ready);
    assign is_good = (q_entry.status == STATUS_GOOD);
    assign is_bad  = (q_entry.status == STATUS_BAD);

    assign yaw_next   = is_good ? q_entry.yaw : yaw_reg;
    assign pitch_next = is_good ? q_entry.pitch : pitch_reg;
    assign roll_next  = is_good ? q_entry.roll : roll_reg;
    assign good_next  = good_reg + 32'(is_good);
    assign bad_next   = bad_reg + 32'(is_bad);

    assign frame.valid = out_valid_reg;
    assign frame.data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            yaw_reg       <= '0;
            pitch_reg     <= '0;
            roll_reg      <= '0;
            good_reg      <= '0;
            bad_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                yaw_reg       <= yaw_next;
                pitch_reg     <= pitch_next;
                roll_reg      <= roll_next;
                good_reg      <= good_next;
                bad_reg       <= bad_next;
                out_valid_reg <= 1'b1;
            end
            else if (frame.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            out_reg.frame_status   <= q_entry.status;
            out_reg.yaw_centideg   <= yaw_next;
            out_reg.pitch_centideg <= pitch_next;
            out_reg.roll_centideg  <= roll_next;
            out_reg.good_frames    <= good_next;
            out_reg.bad_frames     <= bad_next;
        end
    end

endmodule

/* src/imu_rvc_frame_parser.sv */
// ----------------------------------------------------------------------------
// imu_rvc_frame_parser
// Serial IMU frame parser: sliding 19-byte window with header and checksum test
// Path: each byte's entry is written to the queue, then popped into the registered
// result stage that drives the frame stream.
// Throughput: one byte per cycle while the queue has room, with a combinational window shift and checksum tree.
// Reset: clears fill count, angle holds, counters, queue and result valid flag;
// window bytes are not cleared and are never read before being refilled.
// ----------------------------------------------------------------------------
module imu_rvc_frame_parser
    import imu_rvc_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic             clk,
    input  logic             rst_n,
    imu_rvc_stream_if.sink   rx,
    imu_rvc_stream_if.source frame
);

    push_t  q_push;
    logic   q_ready;
    logic   q_pop;
    logic   q_valid;
    entry_t q_entry;

    imu_rvc_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .rx      (rx),
        .q_ready (q_ready),
        .q_push  (q_push)
    );

    imu_rvc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_push  (q_push),
        .q_ready (q_ready),
        .q_pop   (q_pop),
        .q_valid (q_valid),
        .q_entry (q_entry)
    );

    imu_rvc_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_entry (q_entry),
        .q_pop   (q_pop),
        .frame   (frame)
    );

endmodule

/* src/imu_rvc_checker.sv */
// ----------------------------------------------------------------------------
// imu_rvc_checker
// Port-level checks of the result stream, bound to the parser top level
// ----------------------------------------------------------------------------
module imu_rvc_checker
    import imu_rvc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        frame_valid,
    input  logic        frame_ready,
    input  frame_item_t frame_data
);

    logic [31:0]        last_good_reg;
    logic [31:0]        last_bad_reg;
    logic signed [15:0] last_yaw_reg;
    logic signed [15:0] last_pitch_reg;
    logic signed [15:0] last_roll_reg;
    logic               xfer;

    assign xfer = frame_valid && frame_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_good_reg  <= '0;
            last_bad_reg   <= '0;
            last_yaw_reg   <= '0;
            last_pitch_reg <= '0;
            last_roll_reg  <= '0;
        end
        else if (xfer)
        begin
            last_good_reg  <= frame_data.good_frames;
            last_bad_reg   <= frame_data.bad_frames;
            last_yaw_reg   <= frame_data.yaw_centideg;
            last_pitch_reg <= frame_data.pitch_centideg;
            last_roll_reg  <= frame_data.roll_centideg;
        end
    end

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid && !frame_ready |=> frame_valid && $stable(frame_data))
        else $error("result changed while stalled");

    // good count steps by one exactly on good frames
    a_good_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        xfer |-> frame_data.good_frames
                 == last_good_reg + 32'(frame_data.frame_status == STATUS_GOOD))
        else $error("good frame count out of step");

    // bad count steps by one exactly on checksum failures
    a_bad_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        xfer |-> frame_data.bad_frames
                 == last_bad_reg + 32'(frame_data.frame_status == STATUS_BAD))
        else $error("bad frame count out of step");

    // angles only move on a good frame
    a_angles: assert property (@(posedge clk) disable iff (!rst_n)
        xfer && frame_data.frame_status != STATUS_GOOD |->
            frame_data.yaw_centideg == last_yaw_reg
            && frame_data.pitch_centideg == last_pitch_reg
            && frame_data.roll_centideg == last_roll_reg)
        else $error("angles changed without a good frame");

endmodule

bind imu_rvc_frame_parser imu_rvc_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .frame_valid (frame.valid),
    .frame_ready (frame.ready),
    .frame_data  (frame.data)
);
